### sv/whc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whc_pkg: shared types and constants of the word hash counter
// Table geometry, status codes, controller states and the delimiter test.
// ----------------------------------------------------------------------------
package whc_pkg;

   localparam int NUM_SLOTS   = 1024;
   localparam int IDX_BITS    = $clog2(NUM_SLOTS);
   localparam int KEY_BITS    = IDX_BITS;
   localparam int COUNT_BITS  = 16;
   localparam int CHAR_BITS   = 8;
   localparam int RADIX_BITS  = 16;
   localparam int STATUS_BITS = 3;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_BITS'(31);

   localparam logic OP_TEXT  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_NEW    = 3'd0,
      STAT_RAISED = 3'd1,
      STAT_FULL   = 3'd2,
      STAT_FOUND  = 3'd3,
      STAT_ABSENT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;
      logic take;
      logic read;
      logic check;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic finish;
      logic clear_last;
      logic probe_done;
   } stat_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   function automatic logic is_delim(input logic [CHAR_BITS-1:0] c);
      is_delim = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h2C) ||
                 (c == 8'h2E) || (c == 8'h21) || (c == 8'h3A) || (c == 8'h3B) ||
                 (c == 8'h27);
   endfunction

endpackage
`default_nettype wire

### sv/whc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whc_ctrl: sequencer of the word hash counter
// Runs the table clearing sweep, then alternates idle and probe read/check.
// ----------------------------------------------------------------------------
module whc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire whc_pkg::stat_type stat,
   output whc_pkg::cmd_type      cmd,
   output logic                  busy
);

   whc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= whc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         whc_pkg::S_CLEAR: begin
            if (stat.clear_last) state_in = whc_pkg::S_IDLE;
         end
         whc_pkg::S_IDLE: begin
            if (start && stat.finish) state_in = whc_pkg::S_READ;
         end
         whc_pkg::S_READ: begin
            state_in = whc_pkg::S_CHECK;
         end
         whc_pkg::S_CHECK: begin
            state_in = stat.probe_done ? whc_pkg::S_IDLE : whc_pkg::S_READ;
         end
         default: begin
            state_in = whc_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      unique case (state_ff)
         whc_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         whc_pkg::S_IDLE: begin
            busy     = 1'b0;
            cmd.take = start;
         end
         whc_pkg::S_READ: begin
            cmd.read = 1'b1;
         end
         whc_pkg::S_CHECK: begin
            cmd.check = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/whc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whc_datapath: hash, probe and table storage of the word hash counter
// Folds characters into the word hash and walks the triangular probe over
// the slot memory, one read and one check per probe.
// ----------------------------------------------------------------------------
module whc_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire whc_pkg::cmd_type                   cmd,
   output whc_pkg::stat_type                       stat,
   input  wire logic                               req_operation,
   input  wire logic [whc_pkg::CHAR_BITS-1:0]      req_character,
   input  wire logic                               req_end_of_word,
   input  wire logic                               csr_write,
   input  wire logic [whc_pkg::RADIX_BITS-1:0]     csr_data,
   output logic                                    rsp_valid,
   output logic [whc_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [whc_pkg::IDX_BITS-1:0]            rsp_slot,
   output logic [whc_pkg::COUNT_BITS-1:0]          rsp_count
);

   localparam int IB   = whc_pkg::IDX_BITS;
   localparam int CB   = whc_pkg::COUNT_BITS;
   localparam int PB   = whc_pkg::CHAR_BITS + IB;
   localparam int RB   = 2 * IB;

   logic [whc_pkg::RADIX_BITS-1:0] radix_ff;
   logic [IB-1:0]  hash_ff, hash_in;
   logic [IB-1:0]  power_ff, power_in;
   logic           pending_ff, pending_in;
   logic           op_ff;
   logic [IB-1:0]  key_ff;
   logic [IB-1:0]  idx_ff;
   logic [IB-1:0]  step_ff;
   logic [IB-1:0]  step_next;
   logic [IB-1:0]  clr_ff;

   logic [PB-1:0]  char_prod;
   logic [RB-1:0]  power_prod;
   logic [IB-1:0]  hash_upd;
   logic           delim;
   logic           finish;
   logic [IB-1:0]  key_sel;

   whc_pkg::entry_type mem [whc_pkg::NUM_SLOTS];
   whc_pkg::entry_type mem_q;
   whc_pkg::entry_type mem_wdata;
   logic               mem_we;
   logic [IB-1:0]      mem_addr;

   logic           slot_free;
   logic           key_match;
   logic           probe_last;
   logic           probe_done;
   logic [CB-1:0]  count_inc;

   logic                       rsp_valid_ff;
   whc_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [IB-1:0]              rsp_slot_ff, rsp_slot_in;
   logic [CB-1:0]              rsp_count_ff, rsp_count_in;

   // ---- character hashing ----
   assign char_prod  = PB'(req_character) * PB'(power_ff);
   assign power_prod = RB'(power_ff) * RB'(radix_ff[IB-1:0]);
   assign hash_upd   = hash_ff + char_prod[IB-1:0];
   assign delim      = whc_pkg::is_delim(req_character);
   assign finish     = delim ? pending_ff : req_end_of_word;
   assign key_sel    = delim ? hash_ff : hash_upd;

   always_comb begin
      hash_in    = hash_ff;
      power_in   = power_ff;
      pending_in = pending_ff;
      if (cmd.take) begin
         if (finish) begin
            hash_in    = '0;
            power_in   = IB'(1);
            pending_in = 1'b0;
         end else if (!delim) begin
            hash_in    = hash_upd;
            power_in   = power_prod[IB-1:0];
            pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff   <= whc_pkg::RADIX_RESET;
         hash_ff    <= '0;
         power_ff   <= IB'(1);
         pending_ff <= 1'b0;
         clr_ff     <= '0;
      end else begin
         if (csr_write) radix_ff <= csr_data;
         hash_ff    <= hash_in;
         power_ff   <= power_in;
         pending_ff <= pending_in;
         if (cmd.clear) clr_ff <= clr_ff + IB'(1);
      end
   end

   // ---- probe walk ----
   assign step_next  = step_ff + IB'(1);
   assign slot_free  = !mem_q.valid;
   assign key_match  = (mem_q.key == key_ff);
   assign probe_last = (step_ff == IB'(whc_pkg::NUM_SLOTS - 1));
   assign probe_done = slot_free || key_match || probe_last;
   assign count_inc  = (mem_q.count == '1) ? mem_q.count : mem_q.count + CB'(1);

   always_ff @(posedge clock) begin
      if (cmd.take && finish) begin
         op_ff   <= req_operation;
         key_ff  <= key_sel;
         idx_ff  <= key_sel;
         step_ff <= '0;
      end else if (cmd.check && !probe_done) begin
         step_ff <= step_next;
         idx_ff  <= idx_ff + step_next;
      end
   end

   // ---- slot memory ----
   assign mem_addr = cmd.clear ? clr_ff : idx_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = '0;
      if (cmd.clear) begin
         mem_we = 1'b1;
      end else if (cmd.check && (op_ff == whc_pkg::OP_TEXT)) begin
         if (slot_free) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_ff;
            mem_wdata.count = CB'(1);
         end else if (key_match) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = key_ff;
            mem_wdata.count = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.read) mem_q <= mem[idx_ff];
   end

   // ---- result ----
   always_comb begin
      rsp_slot_in  = '0;
      rsp_count_in = '0;
      if (slot_free) begin
         rsp_slot_in = idx_ff;
         if (op_ff == whc_pkg::OP_TEXT) begin
            rsp_status_in = whc_pkg::STAT_NEW;
            rsp_count_in  = CB'(1);
         end else begin
            rsp_status_in = whc_pkg::STAT_ABSENT;
         end
      end else if (key_match) begin
         rsp_slot_in = idx_ff;
         if (op_ff == whc_pkg::OP_TEXT) begin
            rsp_status_in = whc_pkg::STAT_RAISED;
            rsp_count_in  = count_inc;
         end else begin
            rsp_status_in = whc_pkg::STAT_FOUND;
            rsp_count_in  = mem_q.count;
         end
      end else begin
         rsp_status_in = (op_ff == whc_pkg::OP_TEXT) ? whc_pkg::STAT_FULL
                                                      : whc_pkg::STAT_ABSENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.check && probe_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check && probe_done) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign stat.finish     = finish;
   assign stat.clear_last = (clr_ff == IB'(whc_pkg::NUM_SLOTS - 1));
   assign stat.probe_done = probe_done;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;

   // ---- checks ----
   a_rsp_after_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.check))
      else $error("result strobe without a preceding probe check");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (cmd.clear || (cmd.check && op_ff == whc_pkg::OP_TEXT)))
      else $error("table written outside clearing or a text probe");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == whc_pkg::STAT_FULL)
         |-> (rsp_slot_ff == '0 && rsp_count_ff == '0))
      else $error("table full result carries slot or count");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && op_ff == whc_pkg::OP_QUERY) |-> !mem_we)
      else $error("query wrote the table");

endmodule
`default_nettype wire

### sv/word_hash_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// word_hash_counter: word occurrence counter over a character stream
// Hashes words into a 1024-slot open-addressing table and counts or queries.
// ----------------------------------------------------------------------------
// A character is taken when start is high and busy is low. A character that
// ends a word starts a triangular probe walk through the slot memory, busy
// staying high for the walk; each probe is one memory read followed by one
// compare and write-back, probes being 1 to 1024. The result then appears on
// rsp_* with rsp_valid high for exactly one cycle and must be taken in that
// cycle. After reset the block sweeps the slot memory clean, one slot per
// cycle, holding busy high until the sweep ends; the radix register on csr_*
// may be written at any time while busy is low, and also during it.
// ----------------------------------------------------------------------------
module word_hash_counter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_operation,
   input  wire logic [whc_pkg::CHAR_BITS-1:0]      req_character,
   input  wire logic                               req_end_of_word,
   output logic                                    rsp_valid,
   output logic [whc_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [whc_pkg::IDX_BITS-1:0]            rsp_slot,
   output logic [whc_pkg::COUNT_BITS-1:0]          rsp_count,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [whc_pkg::RADIX_BITS-1:0]     csr_data
);

   whc_pkg::cmd_type  cmd;
   whc_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   whc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   whc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_character   (req_character),
      .req_end_of_word (req_end_of_word),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_count       (rsp_count)
   );

endmodule
`default_nettype wire
